// ----- hw/rtl/uartrc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART with RTS/CTS flow control: shared package
// Types, constants and codes used by the transmitter, receiver and top level.
// ----------------------------------------------------------------------------
package uartrc_pkg;

  localparam int DEF_DATA_BITS = 8;
  localparam int CNT_W = 8;
  localparam int IDX_W = 4;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CNT_W-1:0] DEF_BIT_WAIT_LAST = 8'd12;
  localparam logic [CNT_W-1:0] DEF_START_WAIT_LAST = 8'd5;

  localparam logic [CFG_INDEX_W-1:0] CFG_BIT_WAIT_LAST = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_WAIT_LAST = 1'd1;

  typedef struct packed {
    logic       rx_line;
    logic       cts_line;
    logic       send_request;
    logic [7:0] send_byte;
    logic       read_ack;
  } tick_t;

  typedef struct packed {
    logic       tx_level;
    logic       rts_level;
    logic       tx_busy;
    logic       rx_valid;
    logic [7:0] rx_data;
  } result_t;

  typedef struct packed {
    logic en;
    logic level;
  } rts_wr_t;

endpackage

// ----- hw/rtl/uart_tx_rx_rts_cts_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART 8N1 with RTS/CTS flow control: top level
// Each request on the tick channel is one oversampling tick carrying the
// sampled rx and cts lines, an optional send request with its byte, and an
// acknowledge for the received byte. Each tick yields exactly one result on
// the result channel: tx and rts line levels, busy, received-byte valid and
// the held received byte.
// A request is captured in an input register; when it is stepped, the
// transmitter and receiver state advance and the result becomes valid.
// One request is taken every cycle while results are consumed.
// When the result consumer stalls, the result and all state hold; the input
// register keeps one further request and then stalls the tick channel.
// The config port writes the bit and start wait counts; the user is to use
// it only while the block is idle, which the block itself does not enforce.
// Synchronous reset puts both lines idle high, clears busy and valid, and
// loads the default wait counts (12 and 5).
// ----------------------------------------------------------------------------
module uart_tx_rx_rts_cts_top
  import uartrc_pkg::*;
#(
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_stall,
  input  tick_t                  tick,
  output logic                   res_valid,
  input  logic                   res_stall,
  output result_t                res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]       cfg_data
);

  localparam int HOLD_W = (DATA_BITS > 8) ? DATA_BITS : 8;

  logic                 q_valid;
  tick_t                q_tick;
  logic                 step;
  logic [CNT_W-1:0]     bit_wait_last, start_wait_last;
  logic                 tx_out, tx_pending, rx_full;
  logic [DATA_BITS-1:0] rx_hold;
  logic [HOLD_W-1:0]    hold_ext;
  rts_wr_t              tx_rts, rx_rts;
  logic                 rts_out, rts_out_next;

  assign step = q_valid & (~res_valid | ~res_stall);
  assign tick_stall = q_valid & ~step;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (tick_valid && !tick_stall) begin
      q_valid <= 1'b1;
    end else if (step) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_valid && !tick_stall) begin
      q_tick <= tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_wait_last <= DEF_BIT_WAIT_LAST;
      start_wait_last <= DEF_START_WAIT_LAST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BIT_WAIT_LAST: begin
          bit_wait_last <= cfg_data;
        end
        CFG_START_WAIT_LAST: begin
          start_wait_last <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  uartrc_tx #(.DATA_BITS(DATA_BITS)) u_tx (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .tick          (q_tick),
    .bit_wait_last (bit_wait_last),
    .tx_out        (tx_out),
    .tx_pending    (tx_pending),
    .rts_wr        (tx_rts)
  );

  uartrc_rx #(.DATA_BITS(DATA_BITS)) u_rx (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .tick            (q_tick),
    .bit_wait_last   (bit_wait_last),
    .start_wait_last (start_wait_last),
    .rx_full         (rx_full),
    .rx_hold         (rx_hold),
    .rts_wr          (rx_rts)
  );

  // The receiver drives RTS after the transmitter within a tick, so it wins.
  always_comb begin
    rts_out_next = rts_out;
    if (rx_rts.en) begin
      rts_out_next = rx_rts.level;
    end else if (tx_rts.en) begin
      rts_out_next = tx_rts.level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rts_out <= 1'b1;
      res_valid <= 1'b0;
    end else begin
      if (step) begin
        rts_out <= rts_out_next;
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign hold_ext = HOLD_W'(rx_hold);

  always_comb begin
    res.tx_level = tx_out;
    res.rts_level = rts_out;
    res.tx_busy = tx_pending;
    res.rx_valid = rx_full;
    res.rx_data = hold_ext[7:0];
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> (res_valid && res_stall))
    else $error("tick channel stalled without a stalled result");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(step))
    else $error("result became valid without a tick step");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    $fell(rx_full) |-> $past(step && q_tick.read_ack))
    else $error("received byte flag cleared without an acknowledge");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(rts_out) && $stable(tx_pending) && $stable(rx_full))
    else $error("state changed without a tick step");

endmodule

// ----- hw/rtl/uartrc_tx.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART transmitter
// Queues a byte on request and sends start, data bits LSB first and stop.
// ----------------------------------------------------------------------------
module uartrc_tx
  import uartrc_pkg::*;
#(
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tick_t            tick,
  input  logic [CNT_W-1:0] bit_wait_last,
  output logic             tx_out,
  output logic             tx_pending,
  output rts_wr_t          rts_wr
);

  typedef enum logic [4:0] {
    TX_IDLE  = 5'b00001,
    TX_START = 5'b00010,
    TX_WAIT  = 5'b00100,
    TX_BIT   = 5'b01000,
    TX_DONE  = 5'b10000
  } tx_phase_t;

  tx_phase_t              phase, phase_next;
  logic [CNT_W-1:0]       count, count_next;
  logic [IDX_W-1:0]       bit_index, bit_index_next;
  logic [DATA_BITS-1:0]   shift, shift_next;
  logic                   tx_out_next, tx_pending_next;
  logic                   take;
  logic [DATA_BITS-1:0]   shift_v;

  always_comb begin
    take = tick.send_request & ~tx_pending;
    shift_v = take ? DATA_BITS'(tick.send_byte) : shift;
    phase_next = phase;
    count_next = count;
    bit_index_next = bit_index;
    shift_next = shift_v;
    tx_out_next = tx_out;
    tx_pending_next = tx_pending | take;
    rts_wr.en = take;
    rts_wr.level = 1'b0;
    case (phase)
      TX_IDLE: begin
        tx_out_next = 1'b1;
        if (tx_pending_next && !tick.cts_line) begin
          phase_next = TX_START;
        end
      end
      TX_START: begin
        tx_out_next = 1'b0;
        bit_index_next = '0;
        count_next = '0;
        phase_next = TX_WAIT;
      end
      TX_WAIT: begin
        if (count == bit_wait_last) begin
          phase_next = (bit_index == IDX_W'(DATA_BITS + 1)) ? TX_DONE : TX_BIT;
        end
        count_next = count + 1'b1;
      end
      TX_BIT: begin
        count_next = '0;
        if (bit_index < IDX_W'(DATA_BITS)) begin
          tx_out_next = shift_v[0];
          shift_next = shift_v >> 1;
        end else begin
          tx_out_next = 1'b1;
        end
        bit_index_next = bit_index + 1'b1;
        phase_next = TX_WAIT;
      end
      TX_DONE: begin
        tx_pending_next = 1'b0;
        rts_wr.en = 1'b1;
        rts_wr.level = 1'b1;
        phase_next = TX_IDLE;
      end
      default: begin
        phase_next = TX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= TX_IDLE;
      count <= '0;
      bit_index <= '0;
      shift <= '0;
      tx_out <= 1'b1;
      tx_pending <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
      bit_index <= bit_index_next;
      shift <= shift_next;
      tx_out <= tx_out_next;
      tx_pending <= tx_pending_next;
    end
  end

endmodule

// ----- hw/rtl/uartrc_rx.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UART receiver
// Detects a start bit, samples data bits at mid-bit and holds the byte.
// ----------------------------------------------------------------------------
module uartrc_rx
  import uartrc_pkg::*;
#(
  parameter int DATA_BITS = DEF_DATA_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  tick_t                tick,
  input  logic [CNT_W-1:0]     bit_wait_last,
  input  logic [CNT_W-1:0]     start_wait_last,
  output logic                 rx_full,
  output logic [DATA_BITS-1:0] rx_hold,
  output rts_wr_t              rts_wr
);

  typedef enum logic [5:0] {
    RX_IDLE   = 6'b000001,
    RX_START  = 6'b000010,
    RX_ALIGN  = 6'b000100,
    RX_WAIT   = 6'b001000,
    RX_SAMPLE = 6'b010000,
    RX_DONE   = 6'b100000
  } rx_phase_t;

  rx_phase_t            phase, phase_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [IDX_W-1:0]     bit_index, bit_index_next;
  logic [DATA_BITS-1:0] shift, shift_next;
  logic [DATA_BITS-1:0] rx_hold_next;
  logic                 rx_full_next;

  always_comb begin
    phase_next = phase;
    count_next = count;
    bit_index_next = bit_index;
    shift_next = shift;
    rx_hold_next = rx_hold;
    rx_full_next = rx_full & ~tick.read_ack;
    rts_wr.en = 1'b0;
    rts_wr.level = 1'b1;
    case (phase)
      RX_IDLE: begin
        count_next = '0;
        if (!tick.rx_line && !tick.cts_line) begin
          rts_wr.en = 1'b1;
          rts_wr.level = 1'b0;
          phase_next = RX_START;
        end
      end
      RX_START: begin
        if (count == start_wait_last) begin
          phase_next = RX_ALIGN;
        end
        count_next = count + 1'b1;
      end
      RX_ALIGN: begin
        count_next = '0;
        bit_index_next = '0;
        phase_next = RX_WAIT;
      end
      RX_WAIT: begin
        if (count == bit_wait_last) begin
          phase_next = (bit_index == IDX_W'(DATA_BITS)) ? RX_DONE : RX_SAMPLE;
        end
        count_next = count + 1'b1;
      end
      RX_SAMPLE: begin
        bit_index_next = bit_index + 1'b1;
        count_next = '0;
        shift_next = {tick.rx_line, shift[DATA_BITS-1:1]};
        phase_next = RX_WAIT;
      end
      RX_DONE: begin
        if (!rx_full_next) begin
          rx_hold_next = shift;
          rx_full_next = 1'b1;
        end
        rts_wr.en = 1'b1;
        rts_wr.level = 1'b1;
        phase_next = RX_IDLE;
      end
      default: begin
        phase_next = RX_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= RX_IDLE;
      count <= '0;
      bit_index <= '0;
      shift <= '0;
      rx_hold <= '0;
      rx_full <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      count <= count_next;
      bit_index <= bit_index_next;
      shift <= shift_next;
      rx_hold <= rx_hold_next;
      rx_full <= rx_full_next;
    end
  end

endmodule
